FILE: src/sgi_pkg.sv
// Shared types and constants for the sequence gap interpolator.
package sgi_pkg;

  localparam int SAMPLE_W = 32;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int GAP_W    = 6;
  localparam int DIV_W    = GAP_W + 1;

  localparam logic [SAMPLE_W-1:0] MARKER_RESET = 32'hFFFF_D8F1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILL,
    ST_LAST
  } sgi_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dividend;
    logic [DIV_W-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIFF_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/sequence_gap_interpolator.sv
// Top level of the sequence gap interpolator: control sequencer and output register.
//
// The block takes one sample beat at a time. A sample equal to missing_marker
// is a lost measurement: before the first valid sample of a sequence it is
// dropped, otherwise it is counted (saturating at MAX_GAP) and produces no
// output beat. When a valid sample closes a gap of G lost samples, the block
// runs a bit-serial division of the 33-bit difference to the previous valid
// sample by G+1 and then emits G interpolated beats (marked by m_tuser)
// followed by the valid sample itself, one beat per cycle while the output
// side is ready. m_tlast is set on the final beat that a sample produces.
// Input beats are taken only while the sequencer is idle. s_tlast ends a
// sequence and the history clears; on a lost sample it also discards an
// open gap. The missing_marker register resets to -9999; the user must
// write it through cfg_wr_en/cfg_wr_data only while the block is idle,
// which the block itself does not enforce.
module sequence_gap_interpolator #(
  parameter int MAX_GAP = 63
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic        s_tlast,   // end_of_sequence
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic        m_tuser,   // interpolated
  output logic        m_tlast,   // run_last
  // Configuration: missing_marker.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import sgi_pkg::*;

  localparam logic [GAP_W-1:0] MaxGap = GAP_W'(MAX_GAP);

  sgi_state_t state, state_next;

  logic [SAMPLE_W-1:0] missing_marker;
  logic [SAMPLE_W-1:0] previous_valid;
  logic                seen_valid;
  logic [GAP_W-1:0]    gap_count;
  logic [SAMPLE_W-1:0] current;
  logic                current_eos;
  logic [GAP_W-1:0]    fill_left;
  logic signed [DIFF_W-1:0] step;
  logic signed [DIFF_W-1:0] acc;
  logic signed [DIFF_W-1:0] acc_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_beat;
  logic in_missing;
  logic out_free;
  logic load_fill;
  logic load_last;

  assign in_beat    = s_tvalid && s_tready;
  assign in_missing = (s_tdata == missing_marker);
  // The output register can take a new beat when it is empty or being drained.
  assign out_free   = !m_tvalid || m_tready;
  assign acc_next   = acc + step;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat && !in_missing) begin
          if (seen_valid && (gap_count != '0)) state_next = ST_DIV;
          else state_next = ST_LAST;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (out_free && (fill_left == GAP_W'(1))) state_next = ST_LAST;
      end
      ST_LAST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready         = 1'b0;
    load_fill        = 1'b0;
    load_last        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIFF_W'($signed(s_tdata)) - DIFF_W'($signed(previous_valid));
    div_req.divisor  = {1'b0, gap_count} + DIV_W'(1);
    case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        div_req.start = s_tvalid && !in_missing && seen_valid && (gap_count != '0);
      end
      ST_FILL: load_fill = out_free;
      ST_LAST: load_last = out_free;
      default: ;
    endcase
  end

  sgi_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      missing_marker <= MARKER_RESET;
      previous_valid <= '0;
      seen_valid     <= 1'b0;
      gap_count      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) missing_marker <= cfg_wr_data;

      if (in_beat && in_missing) begin
        if (s_tlast) begin
          previous_valid <= '0;
          seen_valid     <= 1'b0;
          gap_count      <= '0;
        end else if (seen_valid && (gap_count < MaxGap)) begin
          gap_count <= gap_count + 1'b1;
        end
      end

      if (load_last) begin
        if (current_eos) begin
          previous_valid <= '0;
          seen_valid     <= 1'b0;
        end else begin
          previous_valid <= current;
          seen_valid     <= 1'b1;
        end
        gap_count <= '0;
      end

      if (load_fill || load_last) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_beat) begin
      current     <= s_tdata;
      current_eos <= s_tlast;
      fill_left   <= gap_count;
    end
    if (div_rsp.done) begin
      step <= div_rsp.quotient;
      acc  <= DIFF_W'($signed(previous_valid));
    end
    if (load_fill) begin
      // Every fill value lies between the two samples, so the low bits suffice.
      acc       <= acc_next;
      fill_left <= fill_left - 1'b1;
      m_tdata   <= acc_next[SAMPLE_W-1:0];
      m_tuser   <= 1'b1;
      m_tlast   <= 1'b0;
    end else if (load_last) begin
      m_tdata <= current;
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
    end
  end

endmodule

FILE: src/sgi_serial_div.sv
// Bit-serial restoring divider, signed dividend, truncation toward zero.
module sgi_serial_div (
  input  logic              clk,
  input  logic              rst,
  input  sgi_pkg::div_req_t req,
  output sgi_pkg::div_rsp_t rsp
);
  import sgi_pkg::*;

  localparam int CNT_W = $clog2(DIFF_W + 1);

  logic [DIFF_W-1:0] mag;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [CNT_W-1:0]  count;
  logic              neg;
  logic              busy;
  logic              done;

  logic [DIV_W:0]    rem_shift;
  logic [DIV_W:0]    rem_sub;
  logic              q_bit;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  assign rem_shift = {rem, mag[DIFF_W-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign q_bit     = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIFF_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg     <= req.dividend[DIFF_W-1];
      mag     <= req.dividend[DIFF_W-1] ? DIFF_W'(-req.dividend) : DIFF_W'(req.dividend);
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      mag <= {mag[DIFF_W-2:0], q_bit};
      rem <= q_bit ? rem_sub[DIV_W-1:0] : rem_shift[DIV_W-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed(mag) : $signed(mag);

endmodule
